[rtl/avtp_mon_pkg.sv]
// ----------------------------------------------------------------------------
// avtp_mon_pkg
// Types and constants for the audio stream receive monitor.
// ----------------------------------------------------------------------------
package avtp_mon_pkg;

	localparam int LockRun     = 8;
	localparam int CounterBits = 32;
	localparam int NumCounters = 11;
	localparam int RunBits     = 4;
	localparam logic [31:0] EarlyLimitNs = 32'd50000000;
	localparam logic [29:0] NsPerSecond  = 30'd1000000000;
	localparam int QueueDepth  = 2;

	// product of samples and one second, dividend of the period division
	localparam int ProdBits = 42;

	typedef enum logic [1:0] {
		REG_LOCK_TOL = 2'd0,
		REG_SAMPLE_RATE = 2'd1,
		REG_SPARSE = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		CNT_FRAMES = 4'd0,
		CNT_UNSUPPORTED = 4'd1,
		CNT_SEQ = 4'd2,
		CNT_RESTART = 4'd3,
		CNT_TVALID = 4'd4,
		CNT_TUNCERT = 4'd5,
		CNT_LATE = 4'd6,
		CNT_EARLY = 4'd7,
		CNT_TMISSING = 4'd8,
		CNT_LOCKED = 4'd9,
		CNT_UNLOCKED = 4'd10
	} cnt_idx_t;

	typedef struct packed {
		logic        action;
		logic [7:0]  sequence_number;
		logic [31:0] presentation_time;
		logic        time_valid;
		logic        time_uncertain;
		logic        media_restart_bit;
		logic        format_good;
		logic [11:0] samples_per_channel;
		logic        now_known;
		logic [31:0] now_low;
		logic [3:0]  counter_select;
	} in_item_t;

	typedef struct packed {
		logic        unsupported;
		logic        sequence_error;
		logic        media_restart_seen;
		logic        late;
		logic        early;
		logic        time_missing;
		logic        locked_now;
		logic        lock_gained;
		logic        lock_lost;
		logic [31:0] counter_value;
	} out_item_t;

	// classified item handed from the front to the back
	typedef struct packed {
		in_item_t    item;
		logic        is_late;
		logic        is_early;
		logic [ProdBits-1:0] product;
	} cls_item_t;

endpackage

[rtl/avtp_mon_front.sv]
// ----------------------------------------------------------------------------
// avtp_mon_front
// Accepts input beats, does the late/early compare and the period product,
// and holds classified items in a short queue for the back end.
// ----------------------------------------------------------------------------
module avtp_mon_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  avtp_mon_pkg::in_item_t in_data,
	output logic                   q_valid,
	input  logic                   q_ready,
	output avtp_mon_pkg::cls_item_t q_data
);

	localparam int PtrBits = $clog2(avtp_mon_pkg::QueueDepth);

	avtp_mon_pkg::cls_item_t mem_q [avtp_mon_pkg::QueueDepth];
	logic [PtrBits-1:0] wr_q, rd_q;
	logic [PtrBits:0]   cnt_q;
	avtp_mon_pkg::cls_item_t cls;
	logic [31:0] diff;
	logic push, pop;

	// classify: timing window and samples times one second
	always_comb begin
		diff = in_data.presentation_time - in_data.now_low;
		cls.item = in_data;
		cls.is_late = in_data.now_known && diff[31];
		cls.is_early = in_data.now_known && !diff[31] && (diff > avtp_mon_pkg::EarlyLimitNs);
		cls.product =
			{{(avtp_mon_pkg::ProdBits-12){1'b0}}, in_data.samples_per_channel} *
			{{(avtp_mon_pkg::ProdBits-30){1'b0}}, avtp_mon_pkg::NsPerSecond};
	end

	assign in_ready = (cnt_q != (PtrBits+1)'(avtp_mon_pkg::QueueDepth));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_data = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
		end
	end

endmodule

[rtl/avtp_mon_div.sv]
// ----------------------------------------------------------------------------
// avtp_mon_div
// Restoring divider, one quotient bit per cycle: nominal packet period.
// ----------------------------------------------------------------------------
module avtp_mon_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [avtp_mon_pkg::ProdBits-1:0]     dividend,
	input  logic [31:0]                           divisor,
	output logic                                  done,
	output logic [avtp_mon_pkg::ProdBits-1:0]     quotient
);

	localparam int N = avtp_mon_pkg::ProdBits;
	localparam int CBits = $clog2(N + 1);

	logic [N-1:0]  quo_q;
	logic [32:0]   rem_q;
	logic [31:0]   dvs_q;
	logic [CBits-1:0] left_q;
	logic          busy_q;
	logic [32:0]   trial;
	logic [33:0]   sub;

	always_comb begin
		trial = {rem_q[31:0], quo_q[N-1]};
		sub = {1'b0, trial} - {2'b0, dvs_q};
	end

	assign quotient = quo_q;

	// one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			left_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				left_q <= CBits'(N);
			end else if (busy_q) begin
				left_q <= left_q - 1'b1;
				if (left_q == CBits'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!sub[33]) begin
				rem_q <= sub[32:0];
				quo_q <= {quo_q[N-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[N-2:0], 1'b0};
			end
		end
	end

endmodule

[rtl/avtp_mon_back.sv]
// ----------------------------------------------------------------------------
// avtp_mon_back
// Executes classified items: stream state, lock tracking, event counters,
// and the result register.
// ----------------------------------------------------------------------------
module avtp_mon_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	output logic                    q_ready,
	input  avtp_mon_pkg::cls_item_t q_data,
	input  logic [31:0]             lock_tol,
	input  logic [31:0]             rate,
	input  logic                    sparse,
	output logic                    out_valid,
	input  logic                    out_ready,
	output avtp_mon_pkg::out_item_t out_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FINISH
	} state_t;

	localparam int N = avtp_mon_pkg::ProdBits;

	state_t state_q;
	avtp_mon_pkg::cls_item_t cur_q;
	logic [avtp_mon_pkg::CounterBits-1:0] cnt_q [avtp_mon_pkg::NumCounters];
	logic [7:0]  last_seq_q;
	logic        last_mr_q, seen_pkt_q;
	logic [31:0] last_stamp_q, last_step_q;
	logic        seen_stamp_q, seen_step_q;
	logic [avtp_mon_pkg::RunBits-1:0] run_q;
	logic        lock_q;

	logic        div_done;
	logic [N-1:0] nominal;
	logic        take, res_load;
	logic [31:0] step, err;
	logic        plausible, steady, lock_chk;
	logic [avtp_mon_pkg::RunBits-1:0] run_nx;
	logic        lock_nx, gained, lost;
	logic        seq_err, mr_seen, tmiss;
	logic [avtp_mon_pkg::NumCounters-1:0] bump;
	logic [31:0] rd_val;
	avtp_mon_pkg::out_item_t rd_res;
	avtp_mon_pkg::in_item_t it;

	assign it = cur_q.item;
	assign q_ready = (state_q == ST_IDLE) && (!out_valid || out_ready);
	assign take = q_valid && q_ready;
	assign res_load = (take && q_data.item.action) || (state_q == ST_FINISH);

	avtp_mon_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (take),
		.dividend (q_data.product),
		.divisor  (rate),
		.done     (div_done),
		.quotient (nominal)
	);

	// item evaluation against stored state
	always_comb begin
		step = it.presentation_time - last_stamp_q;
		err = (step > last_step_q) ? (step - last_step_q) : (last_step_q - step);
		plausible = (rate != '0) &&
			({{(N-32){1'b0}}, step} >= (nominal >> 1)) &&
			({2'b0, {(N-32){1'b0}}, step} < {nominal, 2'b0});
		lock_chk = it.format_good && it.time_valid && seen_stamp_q &&
			(it.samples_per_channel != '0);
		steady = plausible && seen_step_q && (err <= lock_tol);
		run_nx = run_q;
		lock_nx = lock_q;
		gained = 1'b0;
		lost = 1'b0;
		if (lock_chk) begin
			if (steady) begin
				if (run_q < avtp_mon_pkg::RunBits'(avtp_mon_pkg::LockRun))
					run_nx = run_q + 1'b1;
				if (run_nx >= avtp_mon_pkg::RunBits'(avtp_mon_pkg::LockRun) && !lock_q) begin
					lock_nx = 1'b1;
					gained = 1'b1;
				end
			end else begin
				run_nx = '0;
				if (lock_q) begin
					lock_nx = 1'b0;
					lost = 1'b1;
				end
			end
		end
		seq_err = it.format_good && seen_pkt_q && (it.sequence_number != last_seq_q + 8'd1);
		mr_seen = it.format_good && seen_pkt_q && (it.media_restart_bit != last_mr_q);
		tmiss = it.format_good && !it.time_valid && !sparse;
		bump = '0;
		bump[avtp_mon_pkg::CNT_FRAMES] = 1'b1;
		bump[avtp_mon_pkg::CNT_UNSUPPORTED] = !it.format_good;
		bump[avtp_mon_pkg::CNT_SEQ] = seq_err;
		bump[avtp_mon_pkg::CNT_RESTART] = mr_seen;
		bump[avtp_mon_pkg::CNT_TVALID] = it.format_good && it.time_valid;
		bump[avtp_mon_pkg::CNT_TUNCERT] = it.format_good && it.time_valid && it.time_uncertain;
		bump[avtp_mon_pkg::CNT_LATE] = it.format_good && it.time_valid && cur_q.is_late;
		bump[avtp_mon_pkg::CNT_EARLY] = it.format_good && it.time_valid && cur_q.is_early;
		bump[avtp_mon_pkg::CNT_TMISSING] = tmiss;
		bump[avtp_mon_pkg::CNT_LOCKED] = gained;
		bump[avtp_mon_pkg::CNT_UNLOCKED] = lost;
		rd_val = '0;
		if (q_data.item.counter_select < 4'(avtp_mon_pkg::NumCounters))
			rd_val = 32'(cnt_q[q_data.item.counter_select]);
		rd_res = '0;
		rd_res.locked_now = lock_q;
		rd_res.counter_value = rd_val;
	end

	// sequencer, state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			out_data <= '0;
			cur_q <= '0;
			last_seq_q <= '0;
			last_mr_q <= 1'b0;
			seen_pkt_q <= 1'b0;
			last_stamp_q <= '0;
			last_step_q <= '0;
			seen_stamp_q <= 1'b0;
			seen_step_q <= 1'b0;
			run_q <= '0;
			lock_q <= 1'b0;
			for (int i = 0; i < avtp_mon_pkg::NumCounters; i++) cnt_q[i] <= '0;
		end else begin
			if (res_load) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (q_data.item.action) begin
							out_data <= rd_res;
						end else begin
							cur_q <= q_data;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					for (int i = 0; i < avtp_mon_pkg::NumCounters; i++)
						if (bump[i]) cnt_q[i] <= cnt_q[i] + 1'b1;
					out_data.unsupported <= !it.format_good;
					out_data.sequence_error <= seq_err;
					out_data.media_restart_seen <= mr_seen;
					out_data.late <= bump[avtp_mon_pkg::CNT_LATE];
					out_data.early <= bump[avtp_mon_pkg::CNT_EARLY];
					out_data.time_missing <= tmiss;
					out_data.locked_now <= lock_nx;
					out_data.lock_gained <= gained;
					out_data.lock_lost <= lost;
					out_data.counter_value <= '0;
					if (it.format_good) begin
						last_seq_q <= it.sequence_number;
						last_mr_q <= it.media_restart_bit;
						seen_pkt_q <= 1'b1;
						if (it.time_valid) begin
							last_stamp_q <= it.presentation_time;
							seen_stamp_q <= 1'b1;
							if (lock_chk) begin
								last_step_q <= step;
								seen_step_q <= 1'b1;
								run_q <= run_nx;
								lock_q <= lock_nx;
							end
						end
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/avtp_stream_rx_monitor.sv]
// path: a read beat's result passes the front queue and the result register;
// a packet beat also runs the 42-step period divider first
// a packet holds off later items; one read per cycle if idle and not stalled
// reset: arst_n clears all counters, stream state, lock and registers to
// their defaults; no clearing pass is needed
// ----------------------------------------------------------------------------
// avtp_stream_rx_monitor
// Receive-side diagnostic counters and media lock tracking for an audio stream.
// ----------------------------------------------------------------------------
module avtp_stream_rx_monitor (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  avtp_mon_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output avtp_mon_pkg::out_item_t out_data,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [31:0]             cfg_data
);

	logic [31:0] lock_tol_q, rate_q;
	logic        sparse_q;
	logic        q_valid, q_ready;
	avtp_mon_pkg::cls_item_t q_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_tol_q <= 32'd1000;
			rate_q <= 32'd48000;
			sparse_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				avtp_mon_pkg::REG_LOCK_TOL: lock_tol_q <= cfg_data;
				avtp_mon_pkg::REG_SAMPLE_RATE: rate_q <= cfg_data;
				avtp_mon_pkg::REG_SPARSE: sparse_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	avtp_mon_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_data   (q_data)
	);

	avtp_mon_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.lock_tol  (lock_tol_q),
		.rate      (rate_q),
		.sparse    (sparse_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	// an unsupported packet flags no sequence error and no lock change
	a_unsup: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.unsupported |->
		!out_data.sequence_error && !out_data.lock_gained && !out_data.lock_lost)
		else $error("unsupported packet with extra flags");
	// lock gained and lost never together
	a_lock: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.lock_gained && out_data.lock_lost))
		else $error("lock gained and lost at once");
	// gained lock shows as locked
	a_gain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.lock_gained |-> out_data.locked_now)
		else $error("lock gained but not locked");
`endif

endmodule
